@@ rtl/mtb_pkg.sv @@
// Package of the multicore task balancer: sizes, field widths, codes, state
// machine states, the structs between the modules and ring index helpers.
// Depends on nothing; every other file of the block imports it.
package mtb_pkg;

  localparam int MAX_CORES   = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TASK_BITS   = 16;

  localparam int CORE_W = $clog2(MAX_CORES);
  localparam int CNT_W  = $clog2(MAX_CORES + 1);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(MAX_CORES * QUEUE_DEPTH);

  localparam int CORE_CNT_W  = 3;
  localparam int ACTION_W    = 3;
  localparam int CORE_ID_W   = 4;
  localparam int TASK_ID_W   = 16;
  localparam int KIND_W      = 3;
  localparam int CORE_OUT_W  = 2;
  localparam int TASK_RES_W  = 16;
  localparam int QSIZE_W     = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SPAWN    = 3'd0,
    ACT_RUN      = 3'd1,
    ACT_SLEEP    = 3'd2,
    ACT_SHUTDOWN = 3'd3,
    ACT_SIZE     = 3'd4
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    K_ASSIGNED = 3'd0,
    K_RUNNING  = 3'd1,
    K_DELETED  = 3'd2,
    K_SIZE     = 3'd3,
    K_FAIL     = 3'd4,
    K_EMPTY    = 3'd5,
    K_NONE     = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RUN_EMIT,
    ST_STEAL,
    ST_STEAL_WR,
    ST_SLEEP_RD,
    ST_SLEEP_EMIT,
    ST_SHUT_SCAN,
    ST_SHUT_EMIT
  } state_e;

  typedef logic [MAX_CORES-1:0][OCC_W-1:0] occ_arr_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [TASK_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CORE_W-1:0] skip;
    logic              skip_en;
  } sel_req_t;

  typedef struct packed {
    logic [CORE_W-1:0] least;
    logic [CORE_W-1:0] most;
  } sel_rsp_t;

  function automatic logic [ADDR_W-1:0] mem_addr(logic [CORE_W-1:0] core,
                                                 logic [PTR_W-1:0] pos);
    mem_addr = ADDR_W'(int'(core) * QUEUE_DEPTH + int'(pos));
  endfunction

  // Position head + occ (minus one if asked) wrapped into the ring.
  function automatic logic [PTR_W-1:0] ring_pos(logic [PTR_W-1:0] head,
                                                logic [OCC_W-1:0] occ,
                                                logic minus_one);
    logic [PTR_W+1:0] s;
    s = (PTR_W+2)'(head) + (PTR_W+2)'(occ) - (PTR_W+2)'(minus_one);
    if (s >= (PTR_W+2)'(QUEUE_DEPTH)) begin
      s = s - (PTR_W+2)'(QUEUE_DEPTH);
    end
    ring_pos = s[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/mtb_if.sv @@
// Channel interfaces of the multicore task balancer: command input, result
// output and the configuration write channel. Depends on mtb_pkg.
interface mtb_in_if;
  import mtb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [CORE_ID_W-1:0] core_id;
  logic [TASK_ID_W-1:0] task_id;
  modport source (output valid, action, core_id, task_id, input ready);
  modport sink (input valid, action, core_id, task_id, output ready);
endinterface

interface mtb_out_if;
  import mtb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [CORE_OUT_W-1:0] core;
  logic [TASK_RES_W-1:0] task_res;
  logic [QSIZE_W-1:0]    queue_size;
  logic                  last;
  modport source (output valid, kind, core, task_res, queue_size, last, input ready);
  modport sink (input valid, kind, core, task_res, queue_size, last, output ready);
endinterface

interface mtb_cfg_if;
  import mtb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CORE_CNT_W-1:0] core_cnt;
  modport source (output valid, core_cnt, input ready);
  modport sink (input valid, core_cnt, output ready);
endinterface

@@ rtl/multicore_task_balancer_unit.sv @@
// Top level of the multicore task balancer: sequencer, load selection and
// task store. Depends on mtb_pkg, the channel interfaces and the submodules.
//
// Usage:
// - cfg_i, always ready, sets the core count; the user must write it only
//   while no item is in progress, unchecked. Below two the scheduler is off.
// - req_i takes one command item (spawn, run, sleep, shutdown, size query)
//   when the block is idle; rsp_o returns one or more result items, the
//   final one of each command marked by last.
// - Timing: an accepted item is decoded in the next cycle. Spawn, size,
//   failures and an empty core put their result into the result register
//   while decoding. Run reads the head task and then emits it; when the
//   core is or becomes empty, a steal follows that reads the donor's tail
//   task and writes it into that core. Sleep reads and then moves each
//   task in turn until done or refused; shutdown reads and deletes each
//   task of each core in turn, scanning past empty cores, with a none
//   result when nothing is deleted. The task store has a registered read,
//   and the sequencer makes at most one store access per step.
// - The result register holds one item; a stalled receiver holds the
//   sequencer at its next result, while a finished command's last result
//   waiting in the register does not stop the next item being accepted.
// - Reset empties all queues and sets the core count to zero; the task
//   store itself is not cleared and needs no clearing pass.
module multicore_task_balancer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtb_cfg_if.sink   cfg_i,
  mtb_in_if.sink    req_i,
  mtb_out_if.source rsp_o
);
  import mtb_pkg::*;

  mem_req_t             mem_req;
  logic [TASK_BITS-1:0] rdata;
  occ_arr_t             occ;
  logic [CNT_W-1:0]     cnt;
  sel_req_t             sel_req;
  sel_rsp_t             sel_rsp;

  mtb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .mem_o   (mem_req),
    .rdata_i (rdata),
    .occ_o   (occ),
    .cnt_o   (cnt),
    .sel_o   (sel_req),
    .sel_i   (sel_rsp)
  );

  mtb_sel u_sel (
    .occ_i (occ),
    .cnt_i (cnt),
    .req_i (sel_req),
    .rsp_o (sel_rsp)
  );

  mtb_task_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

endmodule

@@ rtl/mtb_task_ram.sv @@
// Task store of all core rings: one write and one registered read port.
// Depends on mtb_pkg for its size and the request struct.
module mtb_task_ram (
  input  logic                          clk_i,
  input  mtb_pkg::mem_req_t             req_i,
  output logic [mtb_pkg::TASK_BITS-1:0] rdata_o
);
  import mtb_pkg::*;

  logic [TASK_BITS-1:0] mem [MAX_CORES*QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

@@ rtl/mtb_sel.sv @@
// Load selection over the active cores: least and most loaded core, with
// an optional core left out and the lowest index winning ties. Uses mtb_pkg.
module mtb_sel (
  input  mtb_pkg::occ_arr_t         occ_i,
  input  logic [mtb_pkg::CNT_W-1:0] cnt_i,
  input  mtb_pkg::sel_req_t         req_i,
  output mtb_pkg::sel_rsp_t         rsp_o
);
  import mtb_pkg::*;

  logic [CORE_W-1:0] least;
  logic [CORE_W-1:0] most;
  logic              have;

  always_comb begin
    least = '0;
    most  = '0;
    have  = 1'b0;
    for (int i = 0; i < MAX_CORES; i++) begin
      if (i < int'(cnt_i) && !(req_i.skip_en && i == int'(req_i.skip))) begin
        if (!have || occ_i[i] < occ_i[least]) begin
          least = CORE_W'(i);
        end
        if (!have || occ_i[i] > occ_i[most]) begin
          most = CORE_W'(i);
        end
        have = 1'b1;
      end
    end
    rsp_o.least = least;
    rsp_o.most  = most;
  end

endmodule

@@ rtl/mtb_ctrl.sv @@
// Command sequencer: per-core head pointers and counts, the active core
// register, task store accesses and the result register. Uses mtb_pkg.
module mtb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mtb_cfg_if.sink                       cfg_i,
  mtb_in_if.sink                        req_i,
  mtb_out_if.source                     rsp_o,
  output mtb_pkg::mem_req_t             mem_o,
  input  logic [mtb_pkg::TASK_BITS-1:0] rdata_i,
  output mtb_pkg::occ_arr_t             occ_o,
  output logic [mtb_pkg::CNT_W-1:0]     cnt_o,
  output mtb_pkg::sel_req_t             sel_o,
  input  mtb_pkg::sel_rsp_t             sel_i
);
  import mtb_pkg::*;

  state_e state_q, state_d;

  logic [CORE_CNT_W-1:0]  ncores_q, ncores_d;
  occ_arr_t               occ_q, occ_d;
  logic [PTR_W-1:0]       head_q [MAX_CORES];
  logic [PTR_W-1:0]       head_d [MAX_CORES];
  logic [CNT_W-1:0]       cur_q, cur_d;

  logic [ACTION_W-1:0]    act_q;
  logic [CORE_ID_W-1:0]   cid_q;
  logic [TASK_BITS-1:0]   task_q;

  logic                   ovalid_q;
  logic [KIND_W-1:0]      okind_q;
  logic [CORE_W-1:0]      ocore_q;
  logic [TASK_BITS-1:0]   otask_q;
  logic [OCC_W-1:0]       osize_q;
  logic                   olast_q;

  logic [CNT_W-1:0]       cnt;
  logic                   cid_ok;
  logic [CORE_W-1:0]      cidx;
  logic [CORE_W-1:0]      curx;
  logic [CORE_W-1:0]      lst;
  logic [CORE_W-1:0]      don;
  logic                   can_load;
  logic                   more;
  logic                   in_fire;

  logic                   emit;
  kind_e                  e_kind;
  logic [CORE_W-1:0]      e_core;
  logic [TASK_BITS-1:0]   e_task;
  logic [OCC_W-1:0]       e_size;
  logic                   e_last;

  assign in_fire     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign ncores_d    = cfg_i.valid ? cfg_i.core_cnt : ncores_q;

  assign cnt = (ncores_q < CORE_CNT_W'(2)) ? '0 :
               (int'(ncores_q) > MAX_CORES) ? CNT_W'(MAX_CORES) : CNT_W'(ncores_q);
  assign cid_ok   = int'(cid_q) < int'(cnt);
  assign cidx     = cid_q[CORE_W-1:0];
  assign curx     = cur_q[CORE_W-1:0];
  assign lst      = sel_i.least;
  assign don      = sel_i.most;
  assign can_load = !ovalid_q || rsp_o.ready;

  assign occ_o = occ_q;
  assign cnt_o = cnt;
  assign sel_o.skip    = (state_q == ST_STEAL) ? curx : cidx;
  assign sel_o.skip_en = (state_q != ST_DISPATCH);

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.kind       = okind_q;
  assign rsp_o.core       = CORE_OUT_W'(ocore_q);
  assign rsp_o.task_res   = TASK_RES_W'(otask_q);
  assign rsp_o.queue_size = QSIZE_W'(osize_q);
  assign rsp_o.last       = olast_q;

  always_comb begin
    more = 1'b0;
    for (int i = 0; i < MAX_CORES; i++) begin
      if (i > int'(cur_q) && i < int'(cnt) && occ_q[i] != '0) begin
        more = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    head_d  = head_q;
    cur_d   = cur_q;
    mem_o   = '0;
    emit    = 1'b0;
    e_kind  = K_FAIL;
    e_core  = '0;
    e_task  = '0;
    e_size  = '0;
    e_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (act_q == ACT_SHUTDOWN) begin
          cur_d   = '0;
          state_d = ST_SHUT_SCAN;
        end else if (act_q inside {ACT_RUN, ACT_SLEEP} && cid_ok && occ_q[cidx] != '0) begin
          cur_d = CNT_W'(cidx);
          if (act_q == ACT_RUN) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = mem_addr(cidx, head_q[cidx]);
            state_d     = ST_RUN_EMIT;
          end else begin
            state_d = ST_SLEEP_RD;
          end
        end else if (can_load) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = ST_IDLE;
          case (act_q)
            ACT_SPAWN: begin
              if (cnt != '0 && task_q != '0) begin
                e_core = lst;
                e_task = task_q;
                if (occ_q[lst] < OCC_W'(QUEUE_DEPTH)) begin
                  e_kind      = K_ASSIGNED;
                  mem_o.we    = 1'b1;
                  mem_o.waddr = mem_addr(lst, ring_pos(head_q[lst], occ_q[lst], 1'b0));
                  mem_o.wdata = task_q;
                  occ_d[lst]  = occ_q[lst] + OCC_W'(1);
                end
              end
            end
            ACT_RUN: begin
              if (cid_ok) begin
                e_kind  = K_EMPTY;
                e_core  = cidx;
                cur_d   = CNT_W'(cidx);
                state_d = ST_STEAL;
              end
            end
            ACT_SLEEP: begin
              if (cid_ok) begin
                e_kind = K_EMPTY;
                e_core = cidx;
              end
            end
            ACT_SIZE: begin
              if (cid_ok) begin
                e_kind = K_SIZE;
                e_core = cidx;
                e_size = occ_q[cidx];
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN_EMIT: begin
        if (can_load) begin
          emit         = 1'b1;
          e_last       = 1'b1;
          e_kind       = K_RUNNING;
          e_core       = curx;
          e_task       = rdata_i;
          head_d[curx] = ring_pos(head_q[curx], OCC_W'(1), 1'b0);
          occ_d[curx]  = occ_q[curx] - OCC_W'(1);
          state_d      = (occ_q[curx] == OCC_W'(1)) ? ST_STEAL : ST_IDLE;
        end
      end
      ST_STEAL: begin
        state_d = ST_IDLE;
        if (occ_q[don] != '0 && occ_q[curx] < OCC_W'(QUEUE_DEPTH)) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = mem_addr(don, ring_pos(head_q[don], occ_q[don], 1'b1));
          occ_d[don]  = occ_q[don] - OCC_W'(1);
          state_d     = ST_STEAL_WR;
        end
      end
      ST_STEAL_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = mem_addr(curx, ring_pos(head_q[curx], occ_q[curx], 1'b0));
        mem_o.wdata = rdata_i;
        occ_d[curx] = occ_q[curx] + OCC_W'(1);
        state_d     = ST_IDLE;
      end
      ST_SLEEP_RD: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = mem_addr(cidx, ring_pos(head_q[cidx], occ_q[cidx], 1'b1));
        state_d     = ST_SLEEP_EMIT;
      end
      ST_SLEEP_EMIT: begin
        if (can_load) begin
          emit   = 1'b1;
          e_core = lst;
          e_task = rdata_i;
          if (occ_q[lst] >= OCC_W'(QUEUE_DEPTH)) begin
            e_last  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            e_kind      = K_ASSIGNED;
            mem_o.we    = 1'b1;
            mem_o.waddr = mem_addr(lst, ring_pos(head_q[lst], occ_q[lst], 1'b0));
            mem_o.wdata = rdata_i;
            occ_d[lst]  = occ_q[lst] + OCC_W'(1);
            occ_d[cidx] = occ_q[cidx] - OCC_W'(1);
            e_last      = (occ_q[cidx] == OCC_W'(1));
            state_d     = e_last ? ST_IDLE : ST_SLEEP_RD;
          end
        end
      end
      ST_SHUT_SCAN: begin
        if (int'(cur_q) >= int'(cnt)) begin
          if (can_load) begin
            emit    = 1'b1;
            e_last  = 1'b1;
            e_kind  = K_NONE;
            state_d = ST_IDLE;
          end
        end else if (occ_q[curx] == '0) begin
          cur_d = cur_q + CNT_W'(1);
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = mem_addr(curx, head_q[curx]);
          state_d     = ST_SHUT_EMIT;
        end
      end
      ST_SHUT_EMIT: begin
        if (can_load) begin
          emit         = 1'b1;
          e_kind       = K_DELETED;
          e_core       = curx;
          e_task       = rdata_i;
          head_d[curx] = ring_pos(head_q[curx], OCC_W'(1), 1'b0);
          occ_d[curx]  = occ_q[curx] - OCC_W'(1);
          e_last       = (occ_q[curx] == OCC_W'(1)) && !more;
          if (e_last) begin
            state_d = ST_IDLE;
          end else begin
            if (occ_q[curx] == OCC_W'(1)) begin
              cur_d = cur_q + CNT_W'(1);
            end
            state_d = ST_SHUT_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncores_q <= '0;
      occ_q    <= '0;
      cur_q    <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < MAX_CORES; i++) begin
        head_q[i] <= '0;
      end
    end else begin
      ncores_q <= ncores_d;
      occ_q    <= occ_d;
      cur_q    <= cur_d;
      head_q   <= head_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= req_i.action;
      cid_q  <= req_i.core_id;
      task_q <= TASK_BITS'(req_i.task_id);
    end
    if (emit) begin
      okind_q <= e_kind;
      ocore_q <= e_core;
      otask_q <= e_task;
      osize_q <= e_size;
      olast_q <= e_last;
    end
  end

endmodule

@@ rtl/mtb_checker.sv @@
// Port-level checks of the multicore task balancer and the bind that
// attaches them to the top level. Depends on mtb_pkg and the top level.
module mtb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [mtb_pkg::KIND_W-1:0]     out_kind_i,
  input logic [mtb_pkg::TASK_RES_W-1:0] out_task_i,
  input logic                           out_last_i
);
  import mtb_pkg::*;

  logic [1:0] open_q, open_d;
  logic       in_fire;
  logic       last_fire;

  assign in_fire   = in_valid_i && in_ready_i;
  assign last_fire = out_valid_i && out_ready_i && out_last_i;
  assign open_d    = open_q + 2'(in_fire) - 2'(last_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_task_i) && $stable(out_last_i))
    else $error("stalled result item changed");

  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 2'd0)
    else $error("result item without an open command");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (open_q == 2'd0) || (open_q == 2'd1 && out_valid_i && out_last_i))
    else $error("new item accepted while the previous one is still at work");

  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != K_ASSIGNED && out_kind_i != K_DELETED |-> out_last_i)
    else $error("single result item not marked last");

endmodule

bind multicore_task_balancer_unit mtb_checker u_mtb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_kind_i  (rsp_o.kind),
  .out_task_i  (rsp_o.task_res),
  .out_last_i  (rsp_o.last)
);
